// ----- rtl/bsort_pkg.sv -----
// Package for the bubble sorter: sizes, transaction payload types, control
// state and the control bundle passed from the sequencer to the cell row.
// Depends on nothing.
`default_nettype none

package bsort_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t in_value;
    logic   in_last;
  } bsort_in_t;

  typedef struct packed {
    value_t out_value;
    logic   out_last;
    logic   overflowed;
  } bsort_out_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } bsort_state_e;

  // Control bundle from the sequencer to the cell row
  typedef struct packed {
    logic             load;    // store the incoming value at slot count
    logic             shift;   // move every value one cell towards the head
    logic             sort;    // run one compare-exchange phase
    logic             desc;    // descending order for this set
    logic             parity;  // pairs starting at even (0) or odd (1) cells
    logic [CNT_W-1:0] count;   // number of values held
  } bsort_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/bsort_cell.sv -----
// One cell of the sorting row: holds one value and exchanges it with its
// neighbours. Depends on bsort_pkg.
`default_nettype none

module bsort_cell (
  input  wire logic                  clk_i,
  input  wire bsort_pkg::bsort_ctrl_t ctrl_i,
  input  wire logic                  load_sel_i,
  input  wire logic                  pair_en_i,
  input  wire bsort_pkg::value_t     in_value_i,
  input  wire bsort_pkg::value_t     left_value_i,
  input  wire bsort_pkg::value_t     right_value_i,
  input  wire logic                  left_swap_i,
  output logic                       swap_o,
  output bsort_pkg::value_t          value_o
);

  bsort_pkg::value_t value_d, value_q;
  logic              wrong_order;

  // Compare with the right neighbour when this cell leads an active pair
  always_comb begin
    if (ctrl_i.desc) begin
      wrong_order = right_value_i > value_q;
    end else begin
      wrong_order = value_q > right_value_i;
    end
    swap_o = ctrl_i.sort & pair_en_i & wrong_order;
  end

  // Select the next value: load, shift towards the head, exchange or hold
  always_comb begin
    value_d = value_q;
    priority if (ctrl_i.load && load_sel_i) begin
      value_d = in_value_i;
    end else if (ctrl_i.shift) begin
      value_d = right_value_i;
    end else if (ctrl_i.sort) begin
      if (swap_o) begin
        value_d = right_value_i;
      end else if (left_swap_i) begin
        value_d = left_value_i;
      end
    end else begin
      value_d = value_q;
    end
  end

  // Hold the value; payload needs no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ----- rtl/bsort_ctrl.sv -----
// Sequencer of the bubble sorter: load, sort and emit states, fill count,
// overflow flag, direction register and phase counting.
// Depends on bsort_pkg.
`default_nettype none

module bsort_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_last_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        out_last_o,
  output logic                        overflowed_o,
  input  wire logic                   cfg_valid_i,
  input  wire logic                   cfg_descending_i,
  output logic                        cfg_ready_o,
  input  wire logic                   any_swap_i,
  output bsort_pkg::bsort_ctrl_t      ctrl_o
);

  bsort_pkg::bsort_state_e         state_d, state_q;
  logic [bsort_pkg::CNT_W-1:0]     count_d, count_q;
  logic [bsort_pkg::CNT_W-1:0]     phase_cnt_d, phase_cnt_q;
  logic                            ovf_d, ovf_q;
  logic                            parity_d, parity_q;
  logic                            clean_d, clean_q;
  logic                            desc_cfg_q;
  logic                            sort_desc_d, sort_desc_q;
  logic                            in_fire, out_fire, room;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = state_q == bsort_pkg::ST_LOAD;
  assign out_valid_o = state_q == bsort_pkg::ST_EMIT;
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_fire    = out_valid_o & out_ready_i;
  assign room        = count_q < bsort_pkg::CNT_W'(bsort_pkg::CAPACITY);

  // Next state and control outputs
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    phase_cnt_d = phase_cnt_q;
    ovf_d       = ovf_q;
    parity_d    = parity_q;
    clean_d     = clean_q;
    sort_desc_d = sort_desc_q;
    ctrl_o      = '0;

    unique case (state_q)
      bsort_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (room) begin
            ctrl_o.load = 1'b1;
            count_d     = count_q + bsort_pkg::CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            sort_desc_d = desc_cfg_q;
            phase_cnt_d = '0;
            parity_d    = 1'b0;
            clean_d     = 1'b0;
            state_d     = bsort_pkg::ST_SORT;
          end
        end
      end
      bsort_pkg::ST_SORT: begin
        ctrl_o.sort = 1'b1;
        phase_cnt_d = phase_cnt_q + bsort_pkg::CNT_W'(1);
        parity_d    = ~parity_q;
        clean_d     = ~any_swap_i;
        // Two clean phases in a row, or a full set of phases, end the sort
        if ((clean_q && !any_swap_i) ||
            (phase_cnt_q == bsort_pkg::CNT_W'(bsort_pkg::CAPACITY - 1))) begin
          state_d = bsort_pkg::ST_EMIT;
        end
      end
      bsort_pkg::ST_EMIT: begin
        if (out_fire) begin
          ctrl_o.shift = 1'b1;
          count_d      = count_q - bsort_pkg::CNT_W'(1);
          if (count_q == bsort_pkg::CNT_W'(1)) begin
            ovf_d   = 1'b0;
            state_d = bsort_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = bsort_pkg::ST_LOAD;
      end
    endcase

    ctrl_o.desc   = sort_desc_q;
    ctrl_o.parity = parity_q;
    ctrl_o.count  = count_q;
  end

  assign out_last_o   = count_q == bsort_pkg::CNT_W'(1);
  assign overflowed_o = ovf_q;

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsort_pkg::ST_LOAD;
      count_q     <= '0;
      phase_cnt_q <= '0;
      ovf_q       <= 1'b0;
      parity_q    <= 1'b0;
      clean_q     <= 1'b0;
      sort_desc_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      phase_cnt_q <= phase_cnt_d;
      ovf_q       <= ovf_d;
      parity_q    <= parity_d;
      clean_q     <= clean_d;
      sort_desc_q <= sort_desc_d;
    end
  end

  // Direction register, written through the configuration channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_cfg_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      desc_cfg_q <= cfg_descending_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bubble_sorter.sv -----
// Top level of the bubble sorter: sequencer plus a row of compare-exchange
// cells. Depends on bsort_pkg, bsort_ctrl and bsort_cell.
`default_nettype none

// Collects a set of up to CAPACITY signed 32-bit values, one per input
// transaction, and returns them sorted (ascending, or descending when the
// direction register is set when the last value arrives). Loading accepts
// one value per cycle; values beyond CAPACITY are dropped and every result
// of the set carries the overflowed flag. After the last value the row of
// cells runs one compare-exchange phase per cycle, alternating between
// even and odd neighbour pairs, for at most CAPACITY phases and stopping
// after two consecutive phases with no exchange. The results then leave
// from the head of the row, one per cycle while the receiver is ready.
// The input is not ready during sorting and emitting, so a new set is only
// taken after the last result of the previous set has left.
module bubble_sorter (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire bsort_pkg::bsort_in_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output bsort_pkg::bsort_out_t      out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic                  cfg_descending_i
);

  bsort_pkg::bsort_ctrl_t             ctrl;
  bsort_pkg::value_t                  cell_value [bsort_pkg::CAPACITY];
  logic [bsort_pkg::CAPACITY-1:0]     swap;
  logic                               out_last, overflowed;

  bsort_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_last_i        (in_data_i.in_last),
    .in_ready_o       (in_ready_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_last_o       (out_last),
    .overflowed_o     (overflowed),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_descending_i (cfg_descending_i),
    .cfg_ready_o      (cfg_ready_o),
    .any_swap_i       (|swap),
    .ctrl_o           (ctrl)
  );

  // Row of cells; cell 0 is the head that results leave from
  for (genvar i = 0; i < bsort_pkg::CAPACITY; i++) begin : g_cell
    logic              load_sel, pair_en, left_swap;
    bsort_pkg::value_t left_value, right_value;

    assign load_sel = ctrl.count == bsort_pkg::CNT_W'(i);

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_swap  = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_swap  = swap[i-1];
    end

    if (i == bsort_pkg::CAPACITY - 1) begin : g_tail
      assign right_value = '0;
      assign pair_en     = 1'b0;
    end else begin : g_pair
      assign right_value = cell_value[i+1];
      assign pair_en     = (ctrl.parity == 1'(i % 2)) &&
                           (bsort_pkg::CNT_W'(i + 1) < ctrl.count);
    end

    bsort_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .load_sel_i    (load_sel),
      .pair_en_i     (pair_en),
      .in_value_i    (in_data_i.in_value),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .left_swap_i   (left_swap),
      .swap_o        (swap[i]),
      .value_o       (cell_value[i])
    );
  end

  // Present the head of the row as the result
  always_comb begin
    out_data_o.out_value  = cell_value[0];
    out_data_o.out_last   = out_last;
    out_data_o.overflowed = overflowed;
  end

endmodule

`default_nettype wire

// ----- rtl/bsort_checker.sv -----
// Port-level checks for the bubble sorter, attached to the top level by a
// bind statement. Depends on bsort_pkg and bubble_sorter.
`default_nettype none

module bsort_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire bsort_pkg::bsort_in_t  in_data_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire bsort_pkg::bsort_out_t out_data_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is shown");

  // The last value of a set closes the input
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.in_last |=> !in_ready_o)
    else $error("input still open after the last value");

  // The last result ends the set
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.out_last |=> !out_valid_o)
    else $error("result shown after the last one");

  // Overflow flag stays the same across one set
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.out_last |=>
      out_valid_o && (out_data_o.overflowed == $past(out_data_o.overflowed)))
    else $error("overflow flag changed within a set");

endmodule

bind bubble_sorter bsort_checker u_bsort_checker (.*);

`default_nettype wire
